// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types, codes and sizes of the ARP cache with request retry.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_DEPTH   = 32;
  localparam int REQUEST_DEPTH = 16;
  localparam int CIDX_W = $clog2(CACHE_DEPTH);
  localparam int CCNT_W = $clog2(CACHE_DEPTH + 1);
  localparam int RIDX_W = $clog2(REQUEST_DEPTH);
  localparam int RCNT_W = $clog2(REQUEST_DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_QUEUE  = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_LOOKUP = 3'd0;
  localparam logic [2:0] KIND_QUEUE  = 3'd1;
  localparam logic [2:0] KIND_INSERT = 3'd2;
  localparam logic [2:0] KIND_SEND   = 3'd3;
  localparam logic [2:0] KIND_DROP   = 3'd4;
  localparam logic [2:0] KIND_TICK   = 3'd5;
  localparam logic [2:0] KIND_ACK    = 3'd6;

  // register indexes
  localparam logic REG_MAX_TRIES = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [3:0]  iface;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [3:0]  iface;
    logic        new_req;
    logic        full;
    logic        last;
  } res_t;

endpackage

// ===== rtl/arpc_front.sv =====
// ----------------------------------------------------------------------------
// arpc_front
// Accepts commands, drops unused codes and queues the rest for the engine.
// ----------------------------------------------------------------------------
module arpc_front import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  cmd_t        in_cmd,
  output logic        q_valid,
  input  logic        q_pop,
  output cmd_t        q_cmd
);

  cmd_t      buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic      wp_r, rp_r;
  logic      push;

  assign in_tready = (cnt_r != 2'd2);
  // drop unused command codes here
  assign push = in_tvalid && in_tready && (in_cmd.cmd <= CMD_CLEAR);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_cmd;
  end

endmodule

// ===== rtl/arpc_engine.sv =====
// ----------------------------------------------------------------------------
// arpc_engine
// Runs commands on entry and request tables, one step a cycle unless stalled.
// ----------------------------------------------------------------------------
module arpc_engine import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  cmd_t        q_cmd,
  input  logic [2:0]  max_tries,
  input  logic [15:0] timeout,
  output logic        out_tvalid,
  input  logic        out_tready,
  output res_t        out_res
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_AGE   = 5'b00100,
    ST_REQ   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r;
  cmd_t   cur_r;

  // entry table (memory, one read and one write a cycle)
  logic [31:0] eip_m  [CACHE_DEPTH];
  logic [47:0] emac_m [CACHE_DEPTH];
  logic [15:0] eage_m [CACHE_DEPTH];
  logic [CCNT_W-1:0] ecnt_r;

  // request table in flip-flops, compared in parallel
  logic [31:0] rip_r  [REQUEST_DEPTH];
  logic [3:0]  rif_r  [REQUEST_DEPTH];
  logic [2:0]  rtry_r [REQUEST_DEPTH];
  logic [RCNT_W-1:0] rcnt_r;

  logic [CCNT_W-1:0] ri_r, wi_r;   // read and write index of the entry sweep
  logic              rd_v_r;        // registered read data valid
  logic [31:0] rd_ip_r;
  logic [47:0] rd_mac_r;
  logic [15:0] rd_age_r;
  logic [RCNT_W-1:0] qi_r;
  res_t        res_r;
  logic        ov_r;

  // parallel request match
  logic              rmatch;
  logic [RIDX_W-1:0] ridx;
  always_comb begin
    rmatch = 1'b0;
    ridx   = '0;
    for (int k = REQUEST_DEPTH - 1; k >= 0; k--) begin
      if ((RCNT_W'(k) < rcnt_r) && rip_r[k] == cur_r.ip) begin
        rmatch = 1'b1;
        ridx   = RIDX_W'(k);
      end
    end
  end

  assign q_pop      = (state_r == ST_IDLE) && q_valid && !ov_r;
  assign out_tvalid = ov_r;
  assign out_res    = res_r;

  logic can_emit;
  logic load_res;
  assign can_emit = !ov_r || out_tready;
  // the output valid flag loads from the request walk and the final emit only
  assign load_res = can_emit && (state_r == ST_REQ || state_r == ST_EMIT);

  // result word of a newly popped command
  res_t start_res;
  always_comb begin
    start_res      = '0;
    start_res.last = 1'b1;
    case (q_cmd.cmd)
      CMD_LOOKUP: start_res.kind = KIND_LOOKUP;
      CMD_QUEUE:  start_res.kind = KIND_QUEUE;
      CMD_INSERT: begin
        start_res.kind = KIND_INSERT;
        start_res.full = (ecnt_r >= CCNT_W'(CACHE_DEPTH));
      end
      CMD_TICK:   start_res.kind = KIND_TICK;
      default:    start_res.kind = KIND_ACK;
    endcase
  end

  // result of one step of the request walk
  logic req_done, req_drop;
  res_t req_res;
  assign req_done = (qi_r >= rcnt_r);
  assign req_drop = (rtry_r[qi_r[RIDX_W-1:0]] >= max_tries);
  always_comb begin
    req_res = '0;
    if (req_done) begin
      req_res.kind = KIND_TICK;
      req_res.last = 1'b1;
    end else if (req_drop) begin
      req_res.kind = KIND_DROP;
      req_res.ip   = rip_r[qi_r[RIDX_W-1:0]];
    end else begin
      req_res.kind  = KIND_SEND;
      req_res.ip    = rip_r[qi_r[RIDX_W-1:0]];
      req_res.iface = rif_r[qi_r[RIDX_W-1:0]];
    end
  end

  // final result of a single-result command
  res_t emit_res;
  always_comb begin
    emit_res = res_r;
    case (cur_r.cmd)
      CMD_INSERT: emit_res.hit = rmatch;
      CMD_QUEUE: begin
        if (!rmatch) begin
          if (rcnt_r < RCNT_W'(REQUEST_DEPTH)) emit_res.new_req = 1'b1;
          else                                 emit_res.full    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    // registered entry read
    rd_ip_r  <= eip_m[ri_r[CIDX_W-1:0]];
    rd_mac_r <= emac_m[ri_r[CIDX_W-1:0]];
    rd_age_r <= eage_m[ri_r[CIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ecnt_r  <= '0;
      rcnt_r  <= '0;
      ov_r    <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      // hold the result until it is taken, refill when a new one is ready
      if (load_res) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_cmd;
            ri_r    <= '0;
            wi_r    <= '0;
            qi_r    <= '0;
            rd_v_r  <= 1'b0;
            res_r   <= start_res;
            case (q_cmd.cmd)
              CMD_LOOKUP: state_r <= ST_SCAN;
              CMD_TICK:   state_r <= ST_AGE;
              CMD_CLEAR: begin
                ecnt_r  <= '0;
                rcnt_r  <= '0;
                state_r <= ST_EMIT;
              end
              CMD_INSERT: begin
                if (ecnt_r < CCNT_W'(CACHE_DEPTH)) begin
                  eip_m[ecnt_r[CIDX_W-1:0]]  <= q_cmd.ip;
                  emac_m[ecnt_r[CIDX_W-1:0]] <= q_cmd.mac;
                  eage_m[ecnt_r[CIDX_W-1:0]] <= '0;
                  ecnt_r <= ecnt_r + 1'b1;
                end
                state_r <= ST_EMIT;
              end
              default: state_r <= ST_EMIT;
            endcase
          end
        end
        ST_SCAN: begin
          // walk entries, oldest first, one per cycle
          if (rd_v_r && rd_ip_r == cur_r.ip) begin
            res_r   <= '{kind: KIND_LOOKUP, hit: 1'b1, mac: rd_mac_r, ip: '0, iface: '0,
                         new_req: 1'b0, full: 1'b0, last: 1'b1};
            state_r <= ST_EMIT;
          end else if (ri_r >= ecnt_r) begin
            state_r <= ST_EMIT;
          end else begin
            rd_v_r <= 1'b1;
            ri_r   <= ri_r + 1'b1;
          end
        end
        ST_AGE: begin
          // compact surviving entries, bumping each age
          if (rd_v_r) begin
            if (rd_age_r < timeout) begin
              eip_m[wi_r[CIDX_W-1:0]]  <= rd_ip_r;
              emac_m[wi_r[CIDX_W-1:0]] <= rd_mac_r;
              eage_m[wi_r[CIDX_W-1:0]] <= rd_age_r + 16'd1;
              wi_r <= wi_r + 1'b1;
            end
          end
          if (ri_r >= ecnt_r) begin
            rd_v_r  <= 1'b0;
            ecnt_r  <= wi_r + CCNT_W'(rd_v_r && rd_age_r < timeout);
            state_r <= ST_REQ;
            ri_r    <= '0;
          end else begin
            rd_v_r <= 1'b1;
            ri_r   <= ri_r + 1'b1;
          end
        end
        ST_REQ: begin
          if (can_emit) begin
            res_r <= req_res;
            if (req_done) begin
              state_r <= ST_IDLE;
            end else if (req_drop) begin
              for (int k = 0; k < REQUEST_DEPTH - 1; k++) begin
                if (RCNT_W'(k) >= qi_r) begin
                  rip_r[k]  <= rip_r[k+1];
                  rif_r[k]  <= rif_r[k+1];
                  rtry_r[k] <= rtry_r[k+1];
                end
              end
              rcnt_r <= rcnt_r - 1'b1;
            end else begin
              rtry_r[qi_r[RIDX_W-1:0]] <= rtry_r[qi_r[RIDX_W-1:0]] + 3'd1;
              qi_r <= qi_r + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (can_emit) begin
            res_r   <= emit_res;
            state_r <= ST_IDLE;
            case (cur_r.cmd)
              CMD_QUEUE: begin
                if (!rmatch && rcnt_r < RCNT_W'(REQUEST_DEPTH)) begin
                  rip_r[rcnt_r[RIDX_W-1:0]]  <= cur_r.ip;
                  rif_r[rcnt_r[RIDX_W-1:0]]  <= cur_r.iface;
                  rtry_r[rcnt_r[RIDX_W-1:0]] <= 3'd0;
                  rcnt_r <= rcnt_r + 1'b1;
                end
              end
              CMD_REMOVE: begin
                if (rmatch) begin
                  for (int k = 0; k < REQUEST_DEPTH - 1; k++) begin
                    if (RIDX_W'(k) >= ridx) begin
                      rip_r[k]  <= rip_r[k+1];
                      rif_r[k]  <= rif_r[k+1];
                      rtry_r[k] <= rtry_r[k+1];
                    end
                  end
                  rcnt_r <= rcnt_r - 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/arp_cache_with_request_retry_top.sv =====
// Lookup sweeps the entries; insert, queue, remove and clear emit a single result.
// Tick: an aging sweep over the entries, then one result per pending request and a final one.
// The engine works on one command at a time and pops the next once the last result is taken.
// A 2-deep queue lets input transfers continue while a result waits.
// Synchronous active-low reset empties both tables and loads register defaults.
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry_top
// ARP cache with aging and pending-request retry, stream in and out.
// ----------------------------------------------------------------------------
module arp_cache_with_request_retry_top import arpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,  // cmd[2:0], ip[34:3], mac[82:35], iface_index[86:83]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata, // hit, mac_res, ip_res, iface_index_res, new_request, full_res
  output logic [2:0]   out_tuser, // kind
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [2:0]  max_tries_r;
  logic [15:0] timeout_r;
  logic q_valid, q_pop;
  cmd_t in_cmd, q_cmd;
  res_t res;

  assign cfg_pready = 1'b1;
  assign in_cmd = '{cmd: in_tdata[2:0], ip: in_tdata[34:3], mac: in_tdata[82:35],
                    iface: in_tdata[86:83]};

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tries_r <= 3'd5;
      timeout_r   <= 16'd30;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_MAX_TRIES) max_tries_r <= cfg_pwdata[2:0];
      else                                timeout_r   <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TIMEOUT) cfg_prdata[15:0] = timeout_r;
    else                             cfg_prdata[2:0]  = max_tries_r;
  end

  arpc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  arpc_engine u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .max_tries(max_tries_r), .timeout(timeout_r),
    .out_tvalid, .out_tready, .out_res(res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {1'b0, res.full, res.new_req, res.iface, res.ip, res.mac, res.hit};

endmodule

// ===== rtl/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the ARP cache result stream.
// ----------------------------------------------------------------------------
module arpc_checker import arpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SEND || out_tuser == KIND_DROP) |-> !out_tlast)
    else $error("send or drop marked last");

  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TICK |-> out_tlast)
    else $error("tick done not marked last");

  a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_LOOKUP |-> out_tdata[48:1] == 48'd0)
    else $error("mac set on non-lookup result");

  a_ready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind arp_cache_with_request_retry_top arpc_checker u_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast, .cfg_pready
);
